@@ src/cca_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types and constants of the cluster chain allocator.
// ----------------------------------------------------------------------------
package cca_pkg;

    localparam int ENTRY_W = 12;
    localparam int BYTE_W  = 20;

    localparam logic [ENTRY_W-1:0] MEDIA_MARK = 12'hFF0;
    localparam logic [ENTRY_W-1:0] END_MARK   = 12'hFFF;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ALLOC = 2'd1,
        OP_LINK  = 2'd2,
        OP_COUNT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [ENTRY_W-1:0] cluster;
        logic [BYTE_W-1:0]  byte_size;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [ENTRY_W-1:0] head_cluster;
        logic [ENTRY_W-1:0] link_value;
        logic [ENTRY_W-1:0] free_count;
        logic [ENTRY_W-1:0] last_allocated;
    } t_rsp;

endpackage

@@ src/cca_chan_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_chan_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface cca_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/cca_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cca_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 62,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/cluster_chain_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_chain_allocator
// FAT12-style cluster table: clear, first-fit chain allocation, link read and
// free count, with the table held in one synchronous RAM.
// ----------------------------------------------------------------------------
// One command is taken at a time; the command port is ready only while the
// block is idle, and the response register lets the next command in while a
// response still waits. The table RAM is scanned one entry per cycle: count
// free scans clusters 2 to LAST_CLUSTER, allocate scans from cluster 2 up
// until the request is met, clear reruns the reset sweep and a link read is
// one RAM read; an out-of-range link or a refused or zero-byte allocate
// answers without a table access. The next command is taken in the cycle
// after the response is loaded; a response not yet taken holds the following one.
// After reset the table is initialized by a sweep over all LAST_CLUSTER+1
// entries, during which no command is accepted.
// ----------------------------------------------------------------------------
module cluster_chain_allocator #(
    parameter int LAST_CLUSTER  = 61,
    parameter int CLUSTER_BYTES = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cca_chan_if.sink   i_cmd,
    cca_chan_if.source o_rsp
);
    import cca_pkg::*;

    localparam int DEPTH       = LAST_CLUSTER + 1;
    localparam int AW          = $clog2(DEPTH);
    localparam int CW          = $clog2(LAST_CLUSTER + 2);
    localparam int PROD_W      = ENTRY_W + $clog2(CLUSTER_BYTES + 1);
    localparam int LIMIT_BYTES = (LAST_CLUSTER - 1) * CLUSTER_BYTES;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_ALLOC,
        S_ALLOC_END,
        S_LINK,
        S_LINK_WAIT,
        S_COUNT,
        S_RESULT
    } t_state;

    t_state             r_state,     n_state;
    logic [CW-1:0]      r_addr,      n_addr;
    logic               r_clr_rsp,   n_clr_rsp;
    logic               r_pend,      n_pend;
    logic [AW-1:0]      r_pend_addr, n_pend_addr;
    logic [AW-1:0]      r_prev,      n_prev;
    logic [BYTE_W-1:0]  r_bytes,     n_bytes;
    logic [ENTRY_W-1:0] r_done,      n_done;
    logic [ENTRY_W-1:0] r_cnt,       n_cnt;
    logic [ENTRY_W-1:0] r_free,      n_free;
    logic [ENTRY_W-1:0] r_last,      n_last;
    logic [ENTRY_W-1:0] r_head,      n_head;
    logic [ENTRY_W-1:0] r_link,      n_link;
    t_status            r_status,    n_status;
    logic               r_rsp_valid, n_rsp_valid;
    t_rsp               r_rsp,       n_rsp;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               cmd_xfer;
    logic [PROD_W-1:0]  free_bytes;

    cca_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign cmd_xfer      = i_cmd.valid && i_cmd.ready;
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    // a request fits when its size is within free clusters times cluster size
    assign free_bytes = PROD_W'(r_free) * PROD_W'(CLUSTER_BYTES);

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_clr_rsp   = r_clr_rsp;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_prev      = r_prev;
        n_bytes     = r_bytes;
        n_done      = r_done;
        n_cnt       = r_cnt;
        n_free      = r_free;
        n_last      = r_last;
        n_head      = r_head;
        n_link      = r_link;
        n_status    = r_status;
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        ram_we      = 1'b0;
        ram_waddr   = r_addr[AW-1:0];
        ram_wdata   = '0;
        ram_raddr   = r_addr[AW-1:0];

        if (o_rsp.valid && o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                ram_we = 1'b1;
                if (r_addr == CW'(0)) begin
                    ram_wdata = MEDIA_MARK;
                end else if (r_addr == CW'(1)) begin
                    ram_wdata = END_MARK;
                end
                if (r_addr == CW'(LAST_CLUSTER)) begin
                    n_free  = ENTRY_W'(LAST_CLUSTER - 1);
                    n_last  = '0;
                    n_state = r_clr_rsp ? S_RESULT : S_IDLE;
                end else begin
                    n_addr = r_addr + CW'(1);
                end
            end
            S_IDLE: begin
                if (cmd_xfer) begin
                    n_status = ST_OK;
                    n_head   = '0;
                    n_link   = '0;
                    unique case (i_cmd.payload.op)
                        OP_CLEAR: begin
                            n_addr    = '0;
                            n_clr_rsp = 1'b1;
                            n_state   = S_INIT;
                        end
                        OP_ALLOC: begin
                            n_bytes = i_cmd.payload.byte_size;
                            n_state = S_CHECK;
                        end
                        OP_LINK: begin
                            if (i_cmd.payload.cluster > ENTRY_W'(LAST_CLUSTER)) begin
                                n_status = ST_RANGE;
                                n_state  = S_RESULT;
                            end else begin
                                n_addr  = i_cmd.payload.cluster[CW-1:0];
                                n_state = S_LINK;
                            end
                        end
                        OP_COUNT: begin
                            n_addr  = CW'(2);
                            n_pend  = 1'b0;
                            n_cnt   = '0;
                            n_state = S_COUNT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CHECK: begin
                if ((32'(r_bytes) > 32'(LIMIT_BYTES)) ||
                    (32'(r_bytes) > 32'(free_bytes))) begin
                    n_status = ST_NOSPACE;
                    n_state  = S_RESULT;
                end else if (r_bytes == '0) begin
                    n_last  = '0;
                    n_state = S_RESULT;
                end else begin
                    n_done  = '0;
                    n_prev  = '0;
                    n_addr  = CW'(2);
                    n_pend  = 1'b0;
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                // link the previous free cluster to the one just found, or make it the head
                if (r_pend && (ram_rdata == '0)) begin
                    if (r_prev != '0) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_prev;
                        ram_wdata = ENTRY_W'(r_pend_addr);
                    end else begin
                        n_head = ENTRY_W'(r_pend_addr);
                    end
                    n_prev = r_pend_addr;
                    n_done = r_done + ENTRY_W'(1);
                    if (r_bytes <= BYTE_W'(CLUSTER_BYTES)) begin
                        n_bytes = '0;
                    end else begin
                        n_bytes = r_bytes - BYTE_W'(CLUSTER_BYTES);
                    end
                end
                if ((n_bytes == '0) || (r_addr > CW'(LAST_CLUSTER))) begin
                    n_pend  = 1'b0;
                    n_state = S_ALLOC_END;
                end else begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_addr[AW-1:0];
                    n_addr      = r_addr + CW'(1);
                end
            end
            S_ALLOC_END: begin
                ram_we    = 1'b1;
                ram_waddr = r_prev;
                ram_wdata = END_MARK;
                n_free    = r_free - r_done;
                n_last    = r_done;
                n_state   = S_RESULT;
            end
            S_LINK: begin
                n_state = S_LINK_WAIT;
            end
            S_LINK_WAIT: begin
                n_link  = ram_rdata;
                n_state = S_RESULT;
            end
            S_COUNT: begin
                if (r_pend && (ram_rdata == '0)) begin
                    n_cnt = r_cnt + ENTRY_W'(1);
                end
                if (r_addr > CW'(LAST_CLUSTER)) begin
                    n_free  = n_cnt;
                    n_pend  = 1'b0;
                    n_state = S_RESULT;
                end else begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_addr[AW-1:0];
                    n_addr      = r_addr + CW'(1);
                end
            end
            S_RESULT: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp_valid          = 1'b1;
                    n_rsp.status         = r_status;
                    n_rsp.head_cluster   = r_head;
                    n_rsp.link_value     = r_link;
                    n_rsp.free_count     = r_free;
                    n_rsp.last_allocated = r_last;
                    n_clr_rsp            = 1'b0;
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_clr_rsp   <= 1'b0;
            r_pend      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_clr_rsp   <= n_clr_rsp;
            r_pend      <= n_pend;
            r_rsp_valid <= n_rsp_valid;
        end
        r_pend_addr <= n_pend_addr;
        r_prev      <= n_prev;
        r_bytes     <= n_bytes;
        r_done      <= n_done;
        r_cnt       <= n_cnt;
        r_free      <= n_free;
        r_last      <= n_last;
        r_head      <= n_head;
        r_link      <= n_link;
        r_status    <= n_status;
        r_rsp       <= n_rsp;
    end

    a_link_behind_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC && ram_we) |-> (ram_waddr < r_pend_addr))
        else $error("chain link written at or ahead of the scan");

    a_done_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |-> (r_done <= r_free))
        else $error("allocated more clusters than are free");

    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT) |-> (r_free <= ENTRY_W'(LAST_CLUSTER - 1)))
        else $error("free count exceeds data clusters");

    a_clear_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_xfer && i_cmd.payload.op == OP_CLEAR) |=> (r_state == S_INIT && r_addr == '0))
        else $error("clear command did not start the table sweep");

endmodule
